[sv/swlct_pkg.sv]
package swlct_pkg;

  localparam int MODE_W     = 4;
  localparam int LAP_IDX_W  = 5;
  localparam int SW_MS_W    = 32;
  localparam int SW_MIN_W   = 17;
  localparam int SW_SEC_W   = 6;
  localparam int SW_CS_W    = 7;
  localparam int SW_SUB_W   = 4;
  localparam int TMR_MIN_W  = 7;
  localparam int TMR_SEC_W  = 6;
  localparam int TMR_MS_W   = 10;

  localparam logic [MODE_W-1:0] MODE_TICK      = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SW_TOGGLE = 4'd1;
  localparam logic [MODE_W-1:0] MODE_LAP       = 4'd2;
  localparam logic [MODE_W-1:0] MODE_SW_CLEAR  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_MIN_UP    = 4'd4;
  localparam logic [MODE_W-1:0] MODE_MIN_DN    = 4'd5;
  localparam logic [MODE_W-1:0] MODE_SEC_UP    = 4'd6;
  localparam logic [MODE_W-1:0] MODE_SEC_DN    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_TMR_START = 4'd8;
  localparam logic [MODE_W-1:0] MODE_READ_LAP  = 4'd9;

  localparam logic [SW_SUB_W-1:0]  SUB_LAST      = 4'd9;
  localparam logic [SW_CS_W-1:0]   CS_LAST       = 7'd99;
  localparam logic [SW_SEC_W-1:0]  SW_SEC_LAST   = 6'd59;
  localparam logic [TMR_MIN_W-1:0] TMR_MIN_LAST  = 7'd99;
  localparam logic [TMR_MIN_W-1:0] TMR_MIN_RESET = 7'd5;
  localparam logic [TMR_SEC_W-1:0] TMR_SEC_LAST  = 6'd59;
  localparam logic [TMR_SEC_W-1:0] TMR_SEC_STEP  = 6'd5;
  localparam logic [TMR_SEC_W-1:0] TMR_SEC_TOP   = 6'd55;
  localparam logic [TMR_MS_W-1:0]  TMR_MS_LAST   = 10'd999;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICK,
    OP_SW_TOGGLE,
    OP_LAP,
    OP_SW_CLEAR,
    OP_MIN_UP,
    OP_MIN_DN,
    OP_SEC_UP,
    OP_SEC_DN,
    OP_TMR_START,
    OP_READ_LAP
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic                 in_range;
    logic [LAP_IDX_W-1:0] idx;
  } entry_t;

endpackage

[sv/swlct_ram.sv]
module swlct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 20
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/swlct_queue.sv]
module swlct_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_stall,
  input  swlct_pkg::entry_t push_entry,
  output logic              pop_valid,
  input  logic              pop_stall,
  output swlct_pkg::entry_t pop_entry
);

  import swlct_pkg::*;

  entry_t     slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_stall = (count == 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_entry  = slot[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[sv/swlct_front.sv]
module swlct_front #(
  parameter int LAP_DEPTH = 20
) (
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic [swlct_pkg::MODE_W-1:0]         mode,
  input  logic [swlct_pkg::LAP_IDX_W-1:0]      lap_index,
  output logic                                 push_valid,
  input  logic                                 push_stall,
  output swlct_pkg::entry_t                    push_entry
);

  import swlct_pkg::*;

  op_t op;

  always_comb begin
    case (mode)
      MODE_TICK:      op = OP_TICK;
      MODE_SW_TOGGLE: op = OP_SW_TOGGLE;
      MODE_LAP:       op = OP_LAP;
      MODE_SW_CLEAR:  op = OP_SW_CLEAR;
      MODE_MIN_UP:    op = OP_MIN_UP;
      MODE_MIN_DN:    op = OP_MIN_DN;
      MODE_SEC_UP:    op = OP_SEC_UP;
      MODE_SEC_DN:    op = OP_SEC_DN;
      MODE_TMR_START: op = OP_TMR_START;
      MODE_READ_LAP:  op = OP_READ_LAP;
      default:        op = OP_NONE;
    endcase
  end

  assign push_entry.op       = op;
  assign push_entry.in_range = (7'(lap_index) < 7'(LAP_DEPTH));
  assign push_entry.idx      = lap_index;
  assign push_valid          = item_valid;
  assign item_stall          = push_stall;

endmodule

[sv/swlct_back.sv]
module swlct_back #(
  parameter int LAP_DEPTH = 20
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    pop_valid,
  output logic                                    pop_stall,
  input  swlct_pkg::entry_t                       pop_entry,
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output logic [swlct_pkg::SW_MIN_W-1:0]          sw_minutes,
  output logic [swlct_pkg::SW_SEC_W-1:0]          sw_seconds,
  output logic [swlct_pkg::SW_CS_W-1:0]           sw_centis,
  output logic                                    sw_active,
  output logic [$clog2(LAP_DEPTH+1)-1:0]          laps_held,
  output logic [swlct_pkg::SW_MS_W-1:0]           lap_ms,
  output logic [swlct_pkg::TMR_MIN_W-1:0]         timer_minutes_shown,
  output logic [swlct_pkg::TMR_SEC_W-1:0]         timer_seconds_shown,
  output logic                                    timer_active,
  output logic                                    alarm_on,
  output logic                                    alarm_pulse
);

  import swlct_pkg::*;

  localparam int CW = $clog2(LAP_DEPTH + 1);
  localparam int AW = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;

  logic                 take;

  logic                 sw_run, sw_run_next;
  logic [SW_MS_W-1:0]   sw_ms, sw_ms_next;
  logic [SW_SUB_W-1:0]  sw_sub, sw_sub_next;
  logic [SW_CS_W-1:0]   sw_cs, sw_cs_next;
  logic [SW_SEC_W-1:0]  sw_sec, sw_sec_next;
  logic [SW_MIN_W-1:0]  sw_min, sw_min_next;
  logic [CW-1:0]        lap_total, lap_total_next;
  logic [TMR_MIN_W-1:0] set_min, set_min_next;
  logic [TMR_SEC_W-1:0] set_sec, set_sec_next;
  logic                 tmr_run, tmr_run_next;
  logic [TMR_MS_W-1:0]  t_ms, t_ms_next;
  logic [TMR_SEC_W-1:0] t_sec, t_sec_next;
  logic [TMR_MIN_W-1:0] t_min, t_min_next;
  logic                 alarm, alarm_next;
  logic                 pulse, pulse_next;
  logic                 lap_hit, lap_hit_next;

  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic [SW_MS_W-1:0]   ram_rdata;
  logic [6:0]           idx_wide;
  logic                 t_last;

  assign take      = pop_valid && (!result_valid || !result_stall);
  assign pop_stall = result_valid && result_stall;

  assign idx_wide  = 7'(pop_entry.idx);
  assign ram_raddr = idx_wide[AW-1:0];
  assign ram_waddr = lap_total[AW-1:0];
  assign t_last    = (t_min == '0) && (t_sec == '0) && (t_ms == TMR_MS_W'(1));

  always_comb begin
    sw_run_next    = sw_run;
    sw_ms_next     = sw_ms;
    sw_sub_next    = sw_sub;
    sw_cs_next     = sw_cs;
    sw_sec_next    = sw_sec;
    sw_min_next    = sw_min;
    lap_total_next = lap_total;
    set_min_next   = set_min;
    set_sec_next   = set_sec;
    tmr_run_next   = tmr_run;
    t_ms_next      = t_ms;
    t_sec_next     = t_sec;
    t_min_next     = t_min;
    alarm_next     = alarm;
    pulse_next     = 1'b0;
    lap_hit_next   = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    case (pop_entry.op)
      OP_TICK: begin
        if (sw_run) begin
          sw_ms_next = sw_ms + SW_MS_W'(1);
          if (sw_ms == '1) begin
            sw_sub_next = '0;
            sw_cs_next  = '0;
            sw_sec_next = '0;
            sw_min_next = '0;
          end else if (sw_sub != SUB_LAST) begin
            sw_sub_next = sw_sub + SW_SUB_W'(1);
          end else begin
            sw_sub_next = '0;
            if (sw_cs != CS_LAST) begin
              sw_cs_next = sw_cs + SW_CS_W'(1);
            end else begin
              sw_cs_next = '0;
              if (sw_sec != SW_SEC_LAST) begin
                sw_sec_next = sw_sec + SW_SEC_W'(1);
              end else begin
                sw_sec_next = '0;
                sw_min_next = sw_min + SW_MIN_W'(1);
              end
            end
          end
        end
        if (tmr_run) begin
          if (t_ms != '0) begin
            t_ms_next = t_ms - TMR_MS_W'(1);
          end else begin
            t_ms_next = TMR_MS_LAST;
            if (t_sec != '0) begin
              t_sec_next = t_sec - TMR_SEC_W'(1);
            end else begin
              t_sec_next = TMR_SEC_LAST;
              t_min_next = t_min - TMR_MIN_W'(1);
            end
          end
          if (t_last) begin
            tmr_run_next = 1'b0;
            alarm_next   = 1'b1;
            pulse_next   = 1'b1;
          end
        end
      end
      OP_SW_TOGGLE: begin
        sw_run_next = !sw_run;
      end
      OP_LAP: begin
        if (sw_run && (lap_total < CW'(LAP_DEPTH))) begin
          ram_we         = take;
          lap_total_next = lap_total + CW'(1);
        end
      end
      OP_SW_CLEAR: begin
        sw_run_next    = 1'b0;
        sw_ms_next     = '0;
        sw_sub_next    = '0;
        sw_cs_next     = '0;
        sw_sec_next    = '0;
        sw_min_next    = '0;
        lap_total_next = '0;
      end
      OP_MIN_UP, OP_MIN_DN, OP_SEC_UP, OP_SEC_DN, OP_TMR_START: begin
        if (alarm) begin
          alarm_next = 1'b0;
        end else if (!tmr_run) begin
          case (pop_entry.op)
            OP_MIN_UP: begin
              set_min_next = (set_min == TMR_MIN_LAST) ? '0 : set_min + TMR_MIN_W'(1);
            end
            OP_MIN_DN: begin
              set_min_next = (set_min == '0) ? TMR_MIN_LAST : set_min - TMR_MIN_W'(1);
            end
            OP_SEC_UP: begin
              set_sec_next = (set_sec >= TMR_SEC_TOP) ? '0 : set_sec + TMR_SEC_STEP;
            end
            OP_SEC_DN: begin
              set_sec_next = (set_sec >= TMR_SEC_STEP) ? set_sec - TMR_SEC_STEP
                                                       : TMR_SEC_TOP;
            end
            default: begin
              if ((set_min != '0) || (set_sec != '0)) begin
                tmr_run_next = 1'b1;
                t_ms_next    = '0;
                t_sec_next   = set_sec;
                t_min_next   = set_min;
              end
            end
          endcase
        end
      end
      OP_READ_LAP: begin
        ram_re       = take;
        lap_hit_next = pop_entry.in_range && (CW'(ram_raddr) < lap_total);
      end
      default: begin
      end
    endcase
  end

  swlct_ram #(
    .WIDTH (SW_MS_W),
    .DEPTH (LAP_DEPTH)
  ) u_lap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (sw_ms),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sw_run       <= 1'b0;
      sw_ms        <= '0;
      sw_sub       <= '0;
      sw_cs        <= '0;
      sw_sec       <= '0;
      sw_min       <= '0;
      lap_total    <= '0;
      set_min      <= TMR_MIN_RESET;
      set_sec      <= '0;
      tmr_run      <= 1'b0;
      t_ms         <= '0;
      t_sec        <= '0;
      t_min        <= '0;
      alarm        <= 1'b0;
      pulse        <= 1'b0;
      lap_hit      <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
      sw_run       <= sw_run_next;
      sw_ms        <= sw_ms_next;
      sw_sub       <= sw_sub_next;
      sw_cs        <= sw_cs_next;
      sw_sec       <= sw_sec_next;
      sw_min       <= sw_min_next;
      lap_total    <= lap_total_next;
      set_min      <= set_min_next;
      set_sec      <= set_sec_next;
      tmr_run      <= tmr_run_next;
      t_ms         <= t_ms_next;
      t_sec        <= t_sec_next;
      t_min        <= t_min_next;
      alarm        <= alarm_next;
      pulse        <= pulse_next;
      lap_hit      <= lap_hit_next;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  assign sw_minutes          = sw_min;
  assign sw_seconds          = sw_sec;
  assign sw_centis           = sw_cs;
  assign sw_active           = sw_run;
  assign laps_held           = lap_total;
  assign lap_ms              = lap_hit ? ram_rdata : '0;
  assign timer_minutes_shown = alarm ? '0 : (tmr_run ? t_min : set_min);
  assign timer_seconds_shown = alarm ? '0 : (tmr_run ? t_sec : set_sec);
  assign timer_active        = tmr_run;
  assign alarm_on            = alarm;
  assign alarm_pulse         = pulse;

  a_run_alarm_excl: assert property (@(posedge clk) disable iff (rst)
    !(tmr_run && alarm))
    else $error("countdown running while alarm pending");

  a_pulse_sets_alarm: assert property (@(posedge clk) disable iff (rst)
    result_valid && pulse |-> alarm && !tmr_run)
    else $error("expiry pulse without alarm");

  a_expire: assert property (@(posedge clk) disable iff (rst)
    take && (pop_entry.op == OP_TICK) && tmr_run && t_last |=> alarm && pulse)
    else $error("countdown missed expiry");

  a_lap_hit_stored: assert property (@(posedge clk) disable iff (rst)
    result_valid && lap_hit |-> (lap_total != '0) && (lap_total <= CW'(LAP_DEPTH)))
    else $error("lap read beyond recorded laps");

endmodule

[sv/stopwatch_laps_countdown_timer_unit.sv]
// Stopwatch with lap memory and countdown timer.
// Input channel (item_valid/item_stall, mode, lap_index): one request per
// millisecond tick or command. Output channel (result_valid/result_stall):
// exactly one result per request, in order, showing the state after that
// request is applied; lap_ms carries the requested lap for a lap read.
// A request accepted into the queue is registered there, then taken by the
// back end, which registers the state after it as the result. One request
// per cycle is sustained while result_stall is low; the state update and
// the lap store read both happen when the back end takes a request, with
// the lap store read data registered in the RAM alongside the result.
// A two-entry queue sits between decode and execute. When result_stall is
// held, the result holds, execution stops, the queue fills, and item_stall
// rises as soon as the queue holds two requests.
// Reset (rst, synchronous) empties the queue, stops both clocks, clears the
// elapsed time, lap count and alarm, and sets the countdown to 5:00. The lap
// store is not cleared; only entries below the lap count are shown on lap_ms.
module stopwatch_laps_countdown_timer_unit #(
  parameter int LAP_DEPTH = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [swlct_pkg::MODE_W-1:0]        mode,
  input  logic [swlct_pkg::LAP_IDX_W-1:0]     lap_index,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [swlct_pkg::SW_MIN_W-1:0]      sw_minutes,
  output logic [swlct_pkg::SW_SEC_W-1:0]      sw_seconds,
  output logic [swlct_pkg::SW_CS_W-1:0]       sw_centis,
  output logic                                sw_active,
  output logic [$clog2(LAP_DEPTH+1)-1:0]      laps_held,
  output logic [swlct_pkg::SW_MS_W-1:0]       lap_ms,
  output logic [swlct_pkg::TMR_MIN_W-1:0]     timer_minutes_shown,
  output logic [swlct_pkg::TMR_SEC_W-1:0]     timer_seconds_shown,
  output logic                                timer_active,
  output logic                                alarm_on,
  output logic                                alarm_pulse
);

  import swlct_pkg::*;

  logic   push_valid;
  logic   push_stall;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_stall;
  entry_t pop_entry;

  swlct_front #(
    .LAP_DEPTH (LAP_DEPTH)
  ) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .mode       (mode),
    .lap_index  (lap_index),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_entry (push_entry)
  );

  swlct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_entry  (pop_entry)
  );

  swlct_back #(
    .LAP_DEPTH (LAP_DEPTH)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .pop_valid           (pop_valid),
    .pop_stall           (pop_stall),
    .pop_entry           (pop_entry),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .sw_minutes          (sw_minutes),
    .sw_seconds          (sw_seconds),
    .sw_centis           (sw_centis),
    .sw_active           (sw_active),
    .laps_held           (laps_held),
    .lap_ms              (lap_ms),
    .timer_minutes_shown (timer_minutes_shown),
    .timer_seconds_shown (timer_seconds_shown),
    .timer_active        (timer_active),
    .alarm_on            (alarm_on),
    .alarm_pulse         (alarm_pulse)
  );

endmodule
